// ===== rtl/core/circle_pair_collision_response_macros.svh =====
// ----------------------------------------------------------------------------
// Circle pair collision response: assertion macros
// Immediate-consequence and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define CPCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle pair collision response: check failed");

// ante holds -> cons holds in the next cycle
`define CPCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle pair collision response: check failed");

`endif

// ===== rtl/core/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: shared package
// Payload structs, pipeline sideband structs and small arithmetic helpers.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic        [7:0]  first_radius;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [7:0]  second_radius;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] new_first_pos_x;
    logic signed [31:0] new_first_pos_y;
    logic signed [31:0] new_first_vel_x;
    logic signed [31:0] new_first_vel_y;
    logic signed [31:0] new_second_pos_x;
    logic signed [31:0] new_second_pos_y;
    logic signed [31:0] new_second_vel_x;
    logic signed [31:0] new_second_vel_y;
    logic               collided;
  } resp_t;

  // travels alongside the square root
  typedef struct packed {
    pair_t       item;
    logic        neg_x;
    logic        neg_y;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [8:0]  rsum;   // r1 + r2 + 1
  } root_side_t;

  // travels alongside the normal divider
  typedef struct packed {
    pair_t       item;
    logic        neg_x;
    logic        neg_y;
    logic        hit;
    logic        dzero;
    logic [31:0] sep;    // half the remaining overlap
  } norm_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = SAT_MAX[31:0];
    else if (v < SAT_MIN) r = SAT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [34:0] div_step(input logic [33:0] cur, input logic [32:0] dvsr);
    logic [33:0] dx;
    logic        ge;
    dx = {1'b0, dvsr};
    ge = cur >= dx;
    return {ge, ge ? cur - dx : cur};
  endfunction

endpackage

// ===== rtl/core/cpcr_isqrt.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: pipelined integer square root
// One root bit per stage over a 66-bit radicand; sideband rides along.
// ----------------------------------------------------------------------------
module cpcr_isqrt import cpcr_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [65:0]   radicand,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [32:0]   root,
  output logic          rem_zero,
  output logic [SW-1:0] side_out
);

  localparam int NS = 33;

  logic          v   [NS+1];
  logic [65:0]   nsh [NS+1];
  logic [32:0]   rt  [NS+1];
  logic [34:0]   rm  [NS+1];
  logic [SW-1:0] sd  [NS+1];

  assign v[0]   = vin;
  assign nsh[0] = radicand;
  assign rt[0]  = '0;
  assign rm[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [36:0] acc;
    logic [36:0] trial;
    logic [36:0] diff;
    logic        ge;

    assign acc   = {rm[k], nsh[k][65:64]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign ge    = acc >= trial;
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nsh[k+1] <= {nsh[k][63:0], 2'b00};
        rt[k+1]  <= {rt[k][31:0], ge};
        rm[k+1]  <= ge ? diff[34:0] : acc[34:0];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign vout     = v[NS];
  assign root     = rt[NS];
  assign rem_zero = (rm[NS] == '0);
  assign side_out = sd[NS];

endmodule

// ===== rtl/core/cpcr_ndiv.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: unit normal divider
// Two restoring dividers in lockstep, |d|*2^F / root, one quotient bit a stage.
// ----------------------------------------------------------------------------
module cpcr_ndiv import cpcr_pkg::*; #(
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [32:0]   mag_x,
  input  logic [32:0]   mag_y,
  input  logic [32:0]   denom,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [FB:0]   quo_x,
  output logic [FB:0]   quo_y,
  output logic [SW-1:0] side_out
);

  localparam int NS = FB + 1;

  logic          v  [NS+1];
  logic [33:0]   rx [NS+1];
  logic [33:0]   ry [NS+1];
  logic [FB:0]   qx [NS+1];
  logic [FB:0]   qy [NS+1];
  logic [32:0]   dv [NS+1];
  logic [SW-1:0] sd [NS+1];

  assign v[0]  = vin;
  assign rx[0] = {1'b0, mag_x};
  assign ry[0] = {1'b0, mag_y};
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign dv[0] = denom;
  assign sd[0] = side_in;

  for (genvar j = 0; j < NS; j++) begin : g_st
    logic [33:0] cur_x;
    logic [33:0] cur_y;
    logic [34:0] stx;
    logic [34:0] sty;

    // first step takes the integer part as is, later steps bring in a zero
    if (j == 0) begin : g_first
      assign cur_x = rx[j];
      assign cur_y = ry[j];
    end else begin : g_rest
      assign cur_x = {rx[j][32:0], 1'b0};
      assign cur_y = {ry[j][32:0], 1'b0};
    end

    assign stx = div_step(cur_x, dv[j]);
    assign sty = div_step(cur_y, dv[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j+1] <= stx[33:0];
        ry[j+1] <= sty[33:0];
        qx[j+1] <= {qx[j][FB-1:0], stx[34]};
        qy[j+1] <= {qy[j][FB-1:0], sty[34]};
        dv[j+1] <= dv[j];
        sd[j+1] <= sd[j];
      end
    end
  end

  assign vout     = v[NS];
  assign quo_x    = qx[NS];
  assign quo_y    = qy[NS];
  assign side_out = sd[NS];

endmodule

// ===== rtl/core/cpcr_resp.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: separation and impulse
// Four stages: products, shift and dot, positions and impulse product, velocities.
// ----------------------------------------------------------------------------
module cpcr_resp import cpcr_pkg::*; #(
  parameter int FB = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [FB:0] quo_x,
  input  logic [FB:0] quo_y,
  input  norm_side_t  side,
  output logic        vout,
  output resp_t       res
);

  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;
  localparam logic signed [FB+35:0] RND_B = $signed({36'd0, {FB{1'b1}}});
  localparam logic signed [FB+36:0] RND_D = $signed({37'd0, {FB{1'b1}}});

  // stage A: normal and products
  logic [FB:0]            nxm;
  logic [FB:0]            nym;
  logic                   nxn;
  logic                   nyn;
  logic signed [FB+1:0]   nxs;
  logic signed [FB+1:0]   nys;
  logic signed [32:0]     dvx;
  logic signed [32:0]     dvy;

  always_comb begin
    nxm = side.dzero ? ONE : quo_x;
    nym = side.dzero ? '0 : quo_y;
    nxn = side.dzero ? 1'b0 : side.neg_x;
    nyn = side.dzero ? 1'b0 : side.neg_y;
    nxs = nxn ? -$signed({1'b0, nxm}) : $signed({1'b0, nxm});
    nys = nyn ? -$signed({1'b0, nym}) : $signed({1'b0, nym});
    dvx = $signed({side.item.first_vel_x[31], side.item.first_vel_x})
        - $signed({side.item.second_vel_x[31], side.item.second_vel_x});
    dvy = $signed({side.item.first_vel_y[31], side.item.first_vel_y})
        - $signed({side.item.second_vel_y[31], side.item.second_vel_y});
  end

  logic                   a_v;
  logic [FB+32:0]         a_px;
  logic [FB+32:0]         a_py;
  logic signed [FB+34:0]  a_ax;
  logic signed [FB+34:0]  a_ay;
  logic signed [FB+1:0]   a_nx;
  logic signed [FB+1:0]   a_ny;
  logic                   a_negx;
  logic                   a_negy;
  logic                   a_hit;
  pair_t                  a_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px   <= nxm * side.sep;
      a_py   <= nym * side.sep;
      a_ax   <= dvx * nxs;
      a_ay   <= dvy * nys;
      a_nx   <= nxs;
      a_ny   <= nys;
      a_negx <= nxn;
      a_negy <= nyn;
      a_hit  <= side.hit;
      a_item <= side.item;
    end
  end

  // stage B: offsets and dot product, truncated toward zero
  logic signed [32:0]     oxs;
  logic signed [32:0]     oys;
  logic signed [FB+35:0]  dsum;
  logic signed [FB+35:0]  dsh;

  always_comb begin
    oxs  = a_negx ? -$signed({1'b0, a_px[FB+31:FB]}) : $signed({1'b0, a_px[FB+31:FB]});
    oys  = a_negy ? -$signed({1'b0, a_py[FB+31:FB]}) : $signed({1'b0, a_py[FB+31:FB]});
    dsum = $signed({a_ax[FB+34], a_ax}) + $signed({a_ay[FB+34], a_ay});
    dsh  = dsum[FB+35] ? (dsum + RND_B) >>> FB : dsum >>> FB;
  end

  logic                   b_v;
  logic signed [32:0]     b_ox;
  logic signed [32:0]     b_oy;
  logic signed [34:0]     b_dot;
  logic signed [FB+1:0]   b_nx;
  logic signed [FB+1:0]   b_ny;
  logic                   b_hit;
  pair_t                  b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ox   <= oxs;
      b_oy   <= oys;
      b_dot  <= dsh[34:0];
      b_nx   <= a_nx;
      b_ny   <= a_ny;
      b_hit  <= a_hit;
      b_item <= a_item;
    end
  end

  // stage C: separated positions, impulse products
  logic signed [39:0] ox40;
  logic signed [39:0] oy40;

  assign ox40 = $signed({{7{b_ox[32]}}, b_ox});
  assign oy40 = $signed({{7{b_oy[32]}}, b_oy});

  logic                   c_v;
  logic signed [31:0]     c_x1;
  logic signed [31:0]     c_y1;
  logic signed [31:0]     c_x2;
  logic signed [31:0]     c_y2;
  logic signed [FB+36:0]  c_ix;
  logic signed [FB+36:0]  c_iy;
  logic                   c_hit;
  pair_t                  c_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (b_hit) begin
        c_x1 <= sat32($signed({{8{b_item.first_pos_x[31]}}, b_item.first_pos_x}) + ox40);
        c_y1 <= sat32($signed({{8{b_item.first_pos_y[31]}}, b_item.first_pos_y}) + oy40);
        c_x2 <= sat32($signed({{8{b_item.second_pos_x[31]}}, b_item.second_pos_x}) - ox40);
        c_y2 <= sat32($signed({{8{b_item.second_pos_y[31]}}, b_item.second_pos_y}) - oy40);
      end else begin
        c_x1 <= b_item.first_pos_x;
        c_y1 <= b_item.first_pos_y;
        c_x2 <= b_item.second_pos_x;
        c_y2 <= b_item.second_pos_y;
      end
      c_ix   <= b_dot * b_nx;
      c_iy   <= b_dot * b_ny;
      c_hit  <= b_hit;
      c_item <= b_item;
    end
  end

  // stage D: impulse applied to velocities
  logic signed [FB+36:0] ixs;
  logic signed [FB+36:0] iys;
  logic signed [39:0]    ix40;
  logic signed [39:0]    iy40;

  always_comb begin
    ixs  = c_ix[FB+36] ? (c_ix + RND_D) >>> FB : c_ix >>> FB;
    iys  = c_iy[FB+36] ? (c_iy + RND_D) >>> FB : c_iy >>> FB;
    ix40 = $signed({{5{ixs[34]}}, ixs[34:0]});
    iy40 = $signed({{5{iys[34]}}, iys[34:0]});
  end

  logic  d_v;
  resp_t d_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_res.new_first_pos_x  <= c_x1;
      d_res.new_first_pos_y  <= c_y1;
      d_res.new_second_pos_x <= c_x2;
      d_res.new_second_pos_y <= c_y2;
      d_res.collided         <= c_hit;
      if (c_hit) begin
        d_res.new_first_vel_x  <=
          sat32($signed({{8{c_item.first_vel_x[31]}}, c_item.first_vel_x}) - ix40);
        d_res.new_first_vel_y  <=
          sat32($signed({{8{c_item.first_vel_y[31]}}, c_item.first_vel_y}) - iy40);
        d_res.new_second_vel_x <=
          sat32($signed({{8{c_item.second_vel_x[31]}}, c_item.second_vel_x}) + ix40);
        d_res.new_second_vel_y <=
          sat32($signed({{8{c_item.second_vel_y[31]}}, c_item.second_vel_y}) + iy40);
      end else begin
        d_res.new_first_vel_x  <= c_item.first_vel_x;
        d_res.new_first_vel_y  <= c_item.first_vel_y;
        d_res.new_second_vel_x <= c_item.second_vel_x;
        d_res.new_second_vel_y <= c_item.second_vel_y;
      end
    end
  end

  assign vout = d_v;
  assign res  = d_res;

endmodule

// ===== rtl/core/circle_pair_collision_response.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: top level
// Contact test, separation along the unit normal and equal-mass velocity swap.
// ----------------------------------------------------------------------------
// One circle pair enters per cycle unless the output stalls, in the default
// Q16.16 format. Three front stages form the centre offset, its squares and
// their sum, 33 stages take the square root one bit each, one stage makes the
// contact decision, FRAC_BITS + 1 stages divide out the unit normal one
// quotient bit each, and four stages apply separation and impulse.
// The last of these is the output register. Every stage advances together
// whenever the output is empty or being taken, so a stalled result holds the
// whole pipe and nothing is dropped or repeated.
`include "circle_pair_collision_response_macros.svh"

module circle_pair_collision_response import cpcr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  pair_valid,
  output logic  pair_ready,
  input  pair_t pair,
  output logic  resp_valid,
  input  logic  resp_ready,
  output resp_t resp
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic en;

  assign en         = !resp_valid || resp_ready;
  assign pair_ready = en;

  // front stage 0: centre offsets
  logic               f0_v;
  pair_t              f0_item;
  logic signed [32:0] f0_dx;
  logic signed [32:0] f0_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
    end else if (en) begin
      f0_v <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_item <= pair;
      f0_dx   <= $signed({pair.first_pos_x[31], pair.first_pos_x})
               - $signed({pair.second_pos_x[31], pair.second_pos_x});
      f0_dy   <= $signed({pair.first_pos_y[31], pair.first_pos_y})
               - $signed({pair.second_pos_y[31], pair.second_pos_y});
    end
  end

  // front stage 1: magnitudes and squares
  logic [32:0] mag_x;
  logic [32:0] mag_y;

  assign mag_x = f0_dx[32] ? 33'(-f0_dx) : 33'(f0_dx);
  assign mag_y = f0_dy[32] ? 33'(-f0_dy) : 33'(f0_dy);

  logic       f1_v;
  logic [65:0] f1_sqx;
  logic [65:0] f1_sqy;
  root_side_t f1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= f0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sqx        <= mag_x * mag_x;
      f1_sqy        <= mag_y * mag_y;
      f1_side.item  <= f0_item;
      f1_side.neg_x <= f0_dx[32];
      f1_side.neg_y <= f0_dy[32];
      f1_side.mag_x <= mag_x;
      f1_side.mag_y <= mag_y;
      f1_side.rsum  <= 9'(f0_item.first_radius) + 9'(f0_item.second_radius) + 9'd1;
    end
  end

  // front stage 2: squared distance
  logic        f2_v;
  logic [65:0] f2_n;
  root_side_t  f2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_n    <= f1_sqx + f1_sqy;
      f2_side <= f1_side;
    end
  end

  // square root
  logic                         sq_v;
  logic [32:0]                  sq_d;
  logic                         sq_rz;
  logic [$bits(root_side_t)-1:0] sq_side_vec;
  root_side_t                   sq_side;

  cpcr_isqrt #(
    .SW($bits(root_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (f2_v),
    .radicand (f2_n),
    .side_in  (f2_side),
    .vout     (sq_v),
    .root     (sq_d),
    .rem_zero (sq_rz),
    .side_out (sq_side_vec)
  );

  assign sq_side = sq_side_vec;

  // contact decision: exact sqrt(n) <= lim
  logic [32:0] lim;
  logic [32:0] gap;
  logic        hit;

  assign lim = 33'(sq_side.rsum) << FRAC_BITS;
  assign gap = lim - sq_d;
  assign hit = (sq_d < lim) || ((sq_d == lim) && sq_rz);

  logic        h_v;
  logic [32:0] h_d;
  logic [32:0] h_magx;
  logic [32:0] h_magy;
  norm_side_t  h_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_d          <= sq_d;
      h_magx       <= sq_side.mag_x;
      h_magy       <= sq_side.mag_y;
      h_side.item  <= sq_side.item;
      h_side.neg_x <= sq_side.neg_x;
      h_side.neg_y <= sq_side.neg_y;
      h_side.hit   <= hit;
      h_side.dzero <= (sq_d == '0);
      h_side.sep   <= gap[32:1];
    end
  end

  // unit normal
  logic                          dv_v;
  logic [FRAC_BITS:0]            dv_qx;
  logic [FRAC_BITS:0]            dv_qy;
  logic [$bits(norm_side_t)-1:0] dv_side_vec;
  norm_side_t                    dv_side;

  cpcr_ndiv #(
    .FB(FRAC_BITS),
    .SW($bits(norm_side_t))
  ) u_ndiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (h_v),
    .mag_x    (h_magx),
    .mag_y    (h_magy),
    .denom    (h_d),
    .side_in  (h_side),
    .vout     (dv_v),
    .quo_x    (dv_qx),
    .quo_y    (dv_qy),
    .side_out (dv_side_vec)
  );

  assign dv_side = dv_side_vec;

  // separation and impulse
  cpcr_resp #(
    .FB(FRAC_BITS)
  ) u_resp (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vin   (dv_v),
    .quo_x (dv_qx),
    .quo_y (dv_qy),
    .side  (dv_side),
    .vout  (resp_valid),
    .res   (resp)
  );

  `CPCR_ASSERT_NXT(a_accept_enters, pair_valid && pair_ready, f0_v)
  `CPCR_ASSERT_IMP(a_coincident_hits, h_v && h_side.dzero, h_side.hit)
  `CPCR_ASSERT_IMP(a_normal_unit, dv_v && dv_side.hit && !dv_side.dzero, (dv_qx <= ONE) && (dv_qy <= ONE))
  `CPCR_ASSERT_NXT(a_stall_holds, resp_valid && !resp_ready, resp_valid && $stable(resp))

endmodule

// ===== tb/cpcr_checker.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: checker
// Watches both channels, predicts each response from the accepted pair and
// compares every field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cpcr_checker import cpcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  pair_valid,
  input  logic  pair_ready,
  input  pair_t pair,
  input  logic  resp_valid,
  input  logic  resp_ready,
  input  resp_t resp,
  output int    errors,
  output int    pending,
  output int    pairs_seen,
  output int    contacts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC = 16;
  localparam longint UNIT = longint'(1) << FRAC;

  resp_t expected_resp_q[$];

  function automatic logic signed [31:0] clamp_word(input longint v);
    logic signed [31:0] w;
    if (v > 64'sd2147483647) w = 32'sh7fffffff;
    else if (v < -64'sd2147483648) w = 32'sh80000000;
    else w = v[31:0];
    return w;
  endfunction

  function automatic resp_t predict_collision(input pair_t p);
    longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy, lim, d;
    longint nx, ny, s, ox, oy, dot, ix, iy;
    logic [71:0] ax, ay, nsq, rem, trial, root, limsq;
    bit hit;
    resp_t r;
    x1 = p.first_pos_x;   y1 = p.first_pos_y;
    vx1 = p.first_vel_x;  vy1 = p.first_vel_y;
    x2 = p.second_pos_x;  y2 = p.second_pos_y;
    vx2 = p.second_vel_x; vy2 = p.second_vel_y;
    dx = x1 - x2;
    dy = y1 - y2;
    lim = (longint'(p.first_radius) + longint'(p.second_radius) + 1) * UNIT;
    ax = 72'((dx < 0) ? -dx : dx);
    ay = 72'((dy < 0) ? -dy : dy);
    nsq = ax * ax + ay * ay;
    root = '0;
    rem = '0;
    // floor square root, two bits of the radicand per step
    for (int k = 70; k >= 0; k -= 2) begin
      rem = (rem << 2) | ((nsq >> k) & 72'd3);
      trial = (root << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 72'd1;
      end else begin
        root = root << 1;
      end
    end
    d = longint'(root);
    limsq = 72'(lim) * 72'(lim);
    hit = (nsq <= limsq);
    if (hit) begin
      if (d == 0) begin
        nx = UNIT;
        ny = 0;
      end else begin
        nx = (dx * UNIT) / d;
        ny = (dy * UNIT) / d;
      end
      s = (lim - d) / 2;
      ox = (nx * s) / UNIT;
      oy = (ny * s) / UNIT;
      x1 += ox; y1 += oy;
      x2 -= ox; y2 -= oy;
      dot = ((vx1 - vx2) * nx + (vy1 - vy2) * ny) / UNIT;
      ix = (dot * nx) / UNIT;
      iy = (dot * ny) / UNIT;
      vx1 -= ix; vy1 -= iy;
      vx2 += ix; vy2 += iy;
    end
    r.new_first_pos_x  = clamp_word(x1);
    r.new_first_pos_y  = clamp_word(y1);
    r.new_first_vel_x  = clamp_word(vx1);
    r.new_first_vel_y  = clamp_word(vy1);
    r.new_second_pos_x = clamp_word(x2);
    r.new_second_pos_y = clamp_word(y2);
    r.new_second_vel_x = clamp_word(vx2);
    r.new_second_vel_y = clamp_word(vy2);
    r.collided         = hit;
    return r;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      errors = 0;
      pairs_seen = 0;
      contacts_seen = 0;
      expected_resp_q.delete();
      pending <= 0;
    end else begin
      if (pair_valid && pair_ready) begin
        e = predict_collision(pair);
        expected_resp_q = {expected_resp_q, e};
        pairs_seen++;
        if (e.collided) contacts_seen++;
      end
      if (resp_valid && resp_ready) begin
        if (expected_resp_q.size() == 0) begin
          errors++;
          $display("%0t: response transaction with nothing expected", $time);
        end else begin
          e = expected_resp_q.pop_front();
          check_field("new_first_pos_x", e.new_first_pos_x, resp.new_first_pos_x);
          check_field("new_first_pos_y", e.new_first_pos_y, resp.new_first_pos_y);
          check_field("new_first_vel_x", e.new_first_vel_x, resp.new_first_vel_x);
          check_field("new_first_vel_y", e.new_first_vel_y, resp.new_first_vel_y);
          check_field("new_second_pos_x", e.new_second_pos_x, resp.new_second_pos_x);
          check_field("new_second_pos_y", e.new_second_pos_y, resp.new_second_pos_y);
          check_field("new_second_vel_x", e.new_second_vel_x, resp.new_second_vel_x);
          check_field("new_second_vel_y", e.new_second_vel_y, resp.new_second_vel_y);
          check_field("collided", e.collided, resp.collided);
        end
      end
      pending <= expected_resp_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision response: testbench top
// Drives directed and random circle pairs in bursts against a stalling
// receiver; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench import cpcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNIT = 1 << 16;
  localparam int RANDOM_PAIRS = 1300;

  logic  clk;
  logic  rst;
  logic  pair_valid;
  logic  pair_ready;
  pair_t pair;
  logic  resp_valid;
  logic  resp_ready = 1'b0;
  resp_t resp;
  int    errors, pending, pairs_seen, contacts_seen;
  int    stall_mode = 0;
  int    stall_left = 0;

  circle_pair_collision_response u_dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp)
  );

  cpcr_checker u_checker (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp),
    .errors(errors), .pending(pending),
    .pairs_seen(pairs_seen), .contacts_seen(contacts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: stretches of no stall, light stall and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: resp_ready <= 1'b1;
      1: resp_ready <= ($urandom_range(0, 3) != 0);
      default: resp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_pair(input pair_t p, input int gap);
    logic took;
    pair_valid <= 1'b1;
    pair <= p;
    forever begin
      @(negedge clk);
      took = pair_ready;
      @(posedge clk);
      if (took) break;
    end
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic pair_t make_pair(input int x1, input int y1, input int vx1, input int vy1,
                                      input int r1, input int x2, input int y2, input int vx2,
                                      input int vy2, input int r2);
    pair_t p;
    p.first_pos_x = x1;  p.first_pos_y = y1;
    p.first_vel_x = vx1; p.first_vel_y = vy1;
    p.first_radius = r1[7:0];
    p.second_pos_x = x2; p.second_pos_y = y2;
    p.second_vel_x = vx2; p.second_vel_y = vy2;
    p.second_radius = r2[7:0];
    return p;
  endfunction

  // every field drawn over its full range
  function automatic pair_t rand_pair();
    pair_t p;
    p.first_pos_x = $urandom;
    p.first_pos_y = $urandom;
    p.first_vel_x = $urandom;
    p.first_vel_y = $urandom;
    p.first_radius = 8'($urandom_range(0, 255));
    p.second_pos_x = $urandom;
    p.second_pos_y = $urandom;
    p.second_vel_x = $urandom;
    p.second_vel_y = $urandom;
    p.second_radius = 8'($urandom_range(0, 255));
    return p;
  endfunction

  // a pair whose centres sit within twice the contact distance on each axis
  function automatic pair_t near_pair();
    pair_t p;
    int reach, ox, oy;
    p = rand_pair();
    p.first_radius = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 20));
    p.second_radius = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 20));
    if ($urandom_range(0, 1)) begin
      p.first_vel_x = $urandom_range(0, 2 * UNIT * 16) - UNIT * 16;
      p.first_vel_y = $urandom_range(0, 2 * UNIT * 16) - UNIT * 16;
      p.second_vel_x = $urandom_range(0, 2 * UNIT * 16) - UNIT * 16;
      p.second_vel_y = $urandom_range(0, 2 * UNIT * 16) - UNIT * 16;
    end
    reach = (p.first_radius + p.second_radius + 1) * UNIT;
    ox = $urandom_range(0, 2 * reach);
    oy = $urandom_range(0, 2 * reach) / ($urandom_range(0, 1) ? 1 : 64);
    if ($urandom_range(0, 1)) ox = -ox;
    if ($urandom_range(0, 1)) oy = -oy;
    if ($urandom_range(0, 15) == 0) begin
      ox = 0;
      oy = 0;
    end
    p.second_pos_x = p.first_pos_x + ox;
    p.second_pos_y = p.first_pos_y + oy;
    return p;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  initial begin
    pair_t directed[$];
    pair_t p;
    int lim;
    rst = 1'b1;
    pair_valid = 1'b0;
    pair = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    lim = 11 * UNIT;
    // coincident centres, zero and largest radii
    directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, make_pair(5 * UNIT, -3 * UNIT, UNIT, 2 * UNIT, 255,
                                    5 * UNIT, -3 * UNIT, -UNIT, 7, 255)};
    // exactly touching, one step past, diagonal contact
    directed = {directed, make_pair(lim, 0, -UNIT, 0, 5, 0, 0, UNIT, 0, 5)};
    directed = {directed, make_pair(lim + 1, 0, -UNIT, 0, 5, 0, 0, UNIT, 0, 5)};
    directed = {directed, make_pair(0, lim, 3, -UNIT, 5, 0, 0, -9, UNIT, 5)};
    directed = {directed, make_pair(7 * UNIT, 7 * UNIT, -UNIT, -UNIT, 5, 0, 0, 0, 0, 5)};
    directed = {directed, make_pair(-4 * UNIT, 3 * UNIT, 12345, -999, 2, 0, 0, -321, 77, 2)};
    // far apart at the extremes of the coordinate range
    directed = {directed, make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                    255, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                    32'h7fffffff, 255)};
    directed = {directed, make_pair(32'h7fffffff, 32'h80000000, -1, -1, 0,
                                    32'h80000000, 32'h7fffffff, -1, -1, 0)};
    // separation pushes a centre past the range
    directed = {directed, make_pair(32'h7fffffff, 0, 0, 0, 10,
                                    32'h7fffffff - UNIT, 0, 0, 0, 10)};
    directed = {directed, make_pair(32'h80000000, 32'h80000000, 0, 0, 200,
                                    32'h80000000 + UNIT, 32'h80000000 + UNIT, 0, 0, 200)};
    // impulse drives velocities past the range
    directed = {directed, make_pair(UNIT, 0, 32'h80000000, 32'h7fffffff, 3,
                                    0, 0, 32'h7fffffff, 32'h80000000, 3)};
    directed = {directed, make_pair(0, UNIT, 32'h7fffffff, 32'h80000000, 3,
                                    0, 0, 32'h80000000, 32'h7fffffff, 3)};
    directed = {directed, make_pair(-UNIT, -UNIT, 32'h7fffffff, 32'h7fffffff, 1,
                                    0, 0, 32'h80000000, 32'h80000000, 1)};
    directed = {directed, make_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                    255, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                    32'hffffffff, 255)};
    directed = {directed, make_pair(1, 0, 5, 5, 0, 0, 0, -5, -5, 0)};
    foreach (directed[i]) send_pair(directed[i], (i % 3 == 0) ? 2 : 0);

    // hold until the pipe drains completely
    pair_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if ($urandom_range(0, 4) == 0) p = rand_pair();
      else p = near_pair();
      send_pair(p, pick_gap());
    end
    pair_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d circle pairs, %0d of them in contact, with bursty input",
             pairs_seen, contacts_seen);
    $display("and a receiver that stalls in varying patterns.");
    if (errors == 0) begin
      $display("PASS circle_pair_collision_response");
    end else begin
      $display("FAIL circle_pair_collision_response");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL circle_pair_collision_response");
    $finish;
  end

endmodule
